// File: design/assert_macros.svh
// Assertion helpers for the display line store back end (shld_back).
// Each use expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SHLD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shld: assertion failed");

// Condition must never be true outside reset.
`define SHLD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("shld: forbidden condition seen");

`endif

// File: design/shld_pkg.sv
// Types, constants and the glyph row function of the scrolling hex display.
// Used by shld_front, shld_queue, shld_back and the top level.
package shld_pkg;

    localparam int LINES          = 32;
    localparam int LINE_AW        = 5;
    localparam int LINE_W         = 32;
    localparam int AMT_W          = 8;
    localparam int GLYPH_ROWS     = 5;
    localparam int ROW_W          = 3;
    localparam int HEX_SCROLL     = 6;
    localparam int HEX_FIRST_LINE = 26;

    // Stream field positions
    localparam int CMD_W     = 2;
    localparam int S_DATA_W  = 48;
    localparam int IDX_LSB   = 0;
    localparam int AMT_LSB   = 5;
    localparam int VAL_LSB   = 13;
    localparam int M_DATA_W  = 32;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_HEX    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_SCROLL,
        OP_CLEAR,
        OP_HEX
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [LINE_AW-1:0]   index;
        logic [LINE_AW-1:0]   amt;    // 1..31 for scroll, 6 for hex
        logic [LINE_W-1:0]    data;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCROLL,
        ST_SCRFIN,
        ST_HEX
    } state_t;

    // Digit d sits in nibble d[2:0] of table d[3], one word per glyph row
    localparam logic [LINE_W-1:0] GLYPH_TAB [2][GLYPH_ROWS] = '{
        '{32'heee8ee4e, 32'h822c886a, 32'h4eeace4a, 32'h4a8e824a, 32'h4ee8eeee},
        '{32'hee6c64ee, 32'h22a2aaaa, 32'h66a26eee, 32'h22a2aa8a, 32'h2e6c6aee}
    };

    // One pixel line of eight glyphs; lowest nibble is drawn leftmost.
    function automatic logic [LINE_W-1:0] glyph_line(input logic [LINE_W-1:0] value,
                                                     input logic [ROW_W-1:0] row);
        logic [LINE_W-1:0] pixels;
        logic [3:0]        digit;
        logic [LINE_W-1:0] tab_word;
        pixels = '0;
        for (int pos = 0; pos < 8; pos++)
        begin
            digit    = value[pos*4 +: 4];
            tab_word = GLYPH_TAB[digit[3]][row];
            pixels[(7-pos)*4 +: 4] = tab_word[digit[2:0]*4 +: 4];
        end
        return pixels;
    endfunction

endpackage

// File: design/shld_front.sv
// Front end: takes stream requests and classifies them into queue entries.
// Depends on shld_pkg.
module shld_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [shld_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [shld_pkg::CMD_W-1:0]      s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output shld_pkg::op_t                   q_op
);

    logic [shld_pkg::AMT_W-1:0] amount;
    logic                       keep;

    assign amount = s_tdata[shld_pkg::AMT_LSB +: shld_pkg::AMT_W];

    always_comb
    begin
        q_op.index = s_tdata[shld_pkg::IDX_LSB +: shld_pkg::LINE_AW];
        q_op.data  = s_tdata[shld_pkg::VAL_LSB +: shld_pkg::LINE_W];
        q_op.amt   = amount[shld_pkg::LINE_AW-1:0];
        q_op.kind  = shld_pkg::OP_WRITE;
        keep       = 1'b1;
        case (shld_pkg::cmd_t'(s_tuser))
            shld_pkg::CMD_WRITE: q_op.kind = shld_pkg::OP_WRITE;
            shld_pkg::CMD_READ:  q_op.kind = shld_pkg::OP_READ;
            shld_pkg::CMD_SCROLL:
            begin
                // scroll by zero changes nothing and is dropped here
                if (amount >= shld_pkg::AMT_W'(shld_pkg::LINES))
                    q_op.kind = shld_pkg::OP_CLEAR;
                else
                    q_op.kind = shld_pkg::OP_SCROLL;
                keep = (amount != '0);
            end
            shld_pkg::CMD_HEX:
            begin
                q_op.kind = shld_pkg::OP_HEX;
                q_op.amt  = shld_pkg::LINE_AW'(shld_pkg::HEX_SCROLL);
            end
            default: q_op.kind = shld_pkg::OP_WRITE;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

// File: design/shld_queue.sv
// Small FIFO of decoded requests between front and back end.
// Depends on shld_pkg.
module shld_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  shld_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output shld_pkg::op_t  head,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shld_pkg::op_t    entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_op;
    end

endmodule

// File: design/shld_back.sv
// Back end: line store memory, scroll/draw sequencer and result register.
// Depends on shld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shld_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  shld_pkg::op_t                   q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [shld_pkg::LINE_W-1:0]     m_tdata
);

    localparam int LINES = shld_pkg::LINES;
    localparam int AW    = shld_pkg::LINE_AW;
    localparam int DW    = shld_pkg::LINE_W;

    logic [DW-1:0] line_mem [LINES];

    shld_pkg::state_t state_reg, state_next;

    logic [LINES-1:0] valid_reg, valid_next;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_vld_reg;
    logic [DW-1:0]    rd_eff;

    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    amt_reg, amt_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             hex_reg, hex_next;
    logic [DW-1:0]    data_reg, data_next;
    logic [shld_pkg::ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic [DW-1:0]    out_data_reg, out_data_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [DW-1:0]    wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic             clr_all;
    logic             clr_tail;
    logic             out_load;

    // never-written lines read as zero
    assign rd_eff   = rd_vld_reg ? rd_data_reg : '0;
    assign out_load = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shld_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == shld_pkg::OP_READ)
                        state_next = shld_pkg::ST_RESP;
                    else if (q_head.kind inside {shld_pkg::OP_SCROLL, shld_pkg::OP_HEX})
                        state_next = shld_pkg::ST_SCROLL;
                end
            end
            shld_pkg::ST_RESP:
                if (out_load)
                    state_next = shld_pkg::ST_IDLE;
            shld_pkg::ST_SCROLL:
                if (src_reg == AW'(LINES - 1))
                    state_next = shld_pkg::ST_SCRFIN;
            shld_pkg::ST_SCRFIN:
                state_next = hex_reg ? shld_pkg::ST_HEX : shld_pkg::ST_IDLE;
            shld_pkg::ST_HEX:
                if (row_reg == shld_pkg::ROW_W'(shld_pkg::GLYPH_ROWS - 1))
                    state_next = shld_pkg::ST_IDLE;
            default: state_next = shld_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = wr_addr_reg;
        wdata          = rd_eff;
        re             = 1'b0;
        raddr          = src_reg;
        clr_all        = 1'b0;
        clr_tail       = 1'b0;
        src_next       = src_reg;
        amt_next       = amt_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = wr_pend_reg;
        hex_next       = hex_reg;
        data_next      = data_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            shld_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        shld_pkg::OP_WRITE:
                        begin
                            we    = 1'b1;
                            waddr = q_head.index;
                            wdata = q_head.data;
                        end
                        shld_pkg::OP_READ:
                        begin
                            re    = 1'b1;
                            raddr = q_head.index;
                        end
                        shld_pkg::OP_CLEAR:
                            clr_all = 1'b1;
                        shld_pkg::OP_SCROLL, shld_pkg::OP_HEX:
                        begin
                            src_next     = q_head.amt;
                            amt_next     = q_head.amt;
                            hex_next     = (q_head.kind == shld_pkg::OP_HEX);
                            data_next    = q_head.data;
                            wr_pend_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            shld_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_eff;
                end
            end
            shld_pkg::ST_SCROLL:
            begin
                // read line src, write it in the next cycle to src - amt
                we           = wr_pend_reg;
                re           = 1'b1;
                raddr        = src_reg;
                src_next     = src_reg + 1'b1;
                wr_pend_next = 1'b1;
                wr_addr_next = src_reg - amt_reg;
            end
            shld_pkg::ST_SCRFIN:
            begin
                we           = wr_pend_reg;
                clr_tail     = 1'b1;
                wr_pend_next = 1'b0;
                row_next     = '0;
            end
            shld_pkg::ST_HEX:
            begin
                we       = 1'b1;
                waddr    = AW'(shld_pkg::HEX_FIRST_LINE) + AW'(row_reg);
                wdata    = shld_pkg::glyph_line(data_reg, row_reg);
                row_next = row_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_all)
            valid_next = '0;
        if (we)
            valid_next[waddr] = 1'b1;
        if (clr_tail)
        begin
            // bottom amt lines become zero
            for (int j = 0; j < LINES; j++)
                if ((AW+1)'(j) >= (AW+1)'(LINES) - {1'b0, amt_reg})
                    valid_next[j] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shld_pkg::ST_IDLE;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
            hex_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            src_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            wr_pend_reg   <= wr_pend_next;
            hex_reg       <= hex_next;
            out_valid_reg <= out_valid_next;
            src_reg       <= src_next;
            row_reg       <= row_next;
            if (re)
                rd_vld_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        wr_addr_reg  <= wr_addr_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            line_mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= line_mem[raddr];
    end

    `SHLD_ASSERT(a_scroll_write_below_read, (state_reg == shld_pkg::ST_SCROLL && wr_pend_reg) |-> (wr_addr_reg < src_reg))
    `SHLD_ASSERT(a_result_from_resp, $rose(out_valid_reg) |-> ($past(state_reg) == shld_pkg::ST_RESP))
    `SHLD_NEVER(a_pop_outside_idle, q_pop && state_reg != shld_pkg::ST_IDLE)
    `SHLD_NEVER(a_hex_row_range, state_reg == shld_pkg::ST_HEX && row_reg >= shld_pkg::ROW_W'(shld_pkg::GLYPH_ROWS))

endmodule

// File: design/scrolling_hex_line_display.sv
// A read passes the request queue, a line memory read and the output register,
// where its result waits while m_axis_tready is low. Write and clear are done
// when popped; scroll by N (1..31) and display-hex move the line memory one
// line per cycle. A request queue lets new requests enter while the back works.
// Reset (rst_n, async, active low) empties the queue and drops the per-line
// valid bits, so every line reads as zero at once; there is no clearing pass.
module scrolling_hex_line_display #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [4:0] line_index, [12:5] scroll_amount, [44:13] data_value, [47:45] zero
    input  logic [shld_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  logic [shld_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_data
    output logic [shld_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    shld_pkg::op_t q_in;
    shld_pkg::op_t q_head;

    shld_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in)
    );

    shld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    shld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

// File: verif/scrolling_hex_line_display_tb.sv
// Testbench for scrolling_hex_line_display: directed and random request streams.
// Needs shld_pkg and the top level; keeps its own line store model for prediction.
module scrolling_hex_line_display_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_ITEMS = 900;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [shld_pkg::S_DATA_W-1:0]   s_axis_tdata;
    logic [shld_pkg::CMD_W-1:0]      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [shld_pkg::M_DATA_W-1:0]   m_axis_tdata;

    // screen as the block should hold it
    logic [31:0]           screen_lines [32];
    logic [31:0]           read_expect_q [$];

    int unsigned           error_count = 0;
    int unsigned           reads_checked = 0;
    int unsigned           n_writes = 0;
    int unsigned           n_reads = 0;
    int unsigned           n_scrolls = 0;
    int unsigned           n_clears = 0;
    int unsigned           n_hex = 0;
    int unsigned           burst_left = 0;
    int unsigned           ready_hold = 0;
    int unsigned           idle_cycles = 0;

    scrolling_hex_line_display u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Glyph words: digit d uses nibble d[2:0] of the word for its upper bit
    function automatic logic [31:0] glyph_word(input logic upper, input int unsigned row);
        logic [31:0] w;
        case ({upper, 3'(row)})
            4'h0: w = 32'heee8ee4e;
            4'h1: w = 32'h822c886a;
            4'h2: w = 32'h4eeace4a;
            4'h3: w = 32'h4a8e824a;
            4'h4: w = 32'h4ee8eeee;
            4'h8: w = 32'hee6c64ee;
            4'h9: w = 32'h22a2aaaa;
            4'ha: w = 32'h66a26eee;
            4'hb: w = 32'h22a2aa8a;
            default: w = 32'h2e6c6aee;
        endcase
        return w;
    endfunction

    // Lowest nibble is shifted in first, so it ends up in bits 31..28
    function automatic logic [31:0] hex_pixel_row(input logic [31:0] value,
                                                  input int unsigned row);
        logic [31:0] pixels;
        logic [3:0]  digit;
        logic [31:0] w;
        pixels = '0;
        for (int unsigned pos = 0; pos < 8; pos++)
        begin
            digit  = 4'(value >> (pos * 4));
            w      = glyph_word(digit[3], row);
            pixels = {pixels[27:0], 4'(w >> (digit[2:0] * 4))};
        end
        return pixels;
    endfunction

    function automatic void shift_screen_up(input int unsigned amount);
        for (int unsigned i = 0; i < shld_pkg::LINES; i++)
            screen_lines[i] = (amount < shld_pkg::LINES && i + amount < shld_pkg::LINES) ?
                              screen_lines[i + amount] : 32'h0;
    endfunction

    function automatic void predict_screen(input shld_pkg::cmd_t cmd, input logic [4:0] idx,
                                           input logic [7:0] amt, input logic [31:0] val);
        case (cmd)
            shld_pkg::CMD_WRITE:
            begin
                screen_lines[idx] = val;
                n_writes++;
            end
            shld_pkg::CMD_READ:
            begin
                read_expect_q.push_back(screen_lines[idx]);
                n_reads++;
            end
            shld_pkg::CMD_SCROLL:
            begin
                shift_screen_up(amt);
                if (amt >= shld_pkg::LINES)
                    n_clears++;
                else
                    n_scrolls++;
            end
            default:
            begin
                shift_screen_up(shld_pkg::HEX_SCROLL);
                for (int unsigned r = 0; r < shld_pkg::GLYPH_ROWS; r++)
                    screen_lines[shld_pkg::HEX_FIRST_LINE + r] = hex_pixel_row(val, r);
                n_hex++;
            end
        endcase
    endfunction

    // One request; valid stays up across a burst and drops between bursts
    task automatic send_request(input shld_pkg::cmd_t cmd, input logic [4:0] idx,
                                input logic [7:0] amt, input logic [31:0] val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, val, amt, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_screen(cmd, idx, amt, val);
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_write_read_extremes();
        send_request(shld_pkg::CMD_WRITE, 5'd0, 8'($urandom), 32'hffffffff);
        send_request(shld_pkg::CMD_WRITE, 5'd31, 8'($urandom), 32'h80000001);
        send_request(shld_pkg::CMD_WRITE, 5'd5, 8'($urandom), 32'h00000000);
        send_request(shld_pkg::CMD_READ, 5'd0, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_READ, 5'd31, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_READ, 5'd17, 8'($urandom), $urandom);
    endtask

    task automatic test_scroll_cases();
        // zero amount leaves the screen alone
        send_request(shld_pkg::CMD_SCROLL, 5'($urandom), 8'd0, $urandom);
        send_request(shld_pkg::CMD_READ, 5'd31, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_SCROLL, 5'($urandom), 8'd1, $urandom);
        send_request(shld_pkg::CMD_READ, 5'd30, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_WRITE, 5'd31, 8'($urandom), 32'h12345678);
        send_request(shld_pkg::CMD_SCROLL, 5'($urandom), 8'd31, $urandom);
        send_request(shld_pkg::CMD_READ, 5'd0, 8'($urandom), $urandom);
        // 32 and above wipe everything
        send_request(shld_pkg::CMD_WRITE, 5'd9, 8'($urandom), 32'hdeadbeef);
        send_request(shld_pkg::CMD_SCROLL, 5'($urandom), 8'd32, $urandom);
        send_request(shld_pkg::CMD_READ, 5'd9, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_WRITE, 5'd3, 8'($urandom), 32'h5a5a5a5a);
        send_request(shld_pkg::CMD_SCROLL, 5'($urandom), 8'd255, $urandom);
        send_request(shld_pkg::CMD_READ, 5'd3, 8'($urandom), $urandom);
    endtask

    task automatic test_hex_layout();
        send_request(shld_pkg::CMD_WRITE, 5'd30, 8'($urandom), 32'hc0ffee11);
        send_request(shld_pkg::CMD_HEX, 5'($urandom), 8'($urandom), 32'h76543210);
        for (int unsigned i = shld_pkg::HEX_FIRST_LINE; i < shld_pkg::LINES; i++)
            send_request(shld_pkg::CMD_READ, 5'(i), 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_HEX, 5'($urandom), 8'($urandom), 32'hfedcba98);
        send_request(shld_pkg::CMD_READ, 5'd24, 8'($urandom), $urandom);
        send_request(shld_pkg::CMD_READ, 5'd28, 8'($urandom), $urandom);
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned sent;
        int unsigned k;
        logic [4:0]  touched [$];
        logic [4:0]  idx;
        logic [7:0]  amt;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    send_request(shld_pkg::cmd_t'($urandom_range(0, 3)), 5'($urandom),
                                 8'($urandom), $urandom);
                    sent++;
                end
                3, 4:
                begin
                    // fill some lines, then read them back
                    touched.delete();
                    k = $urandom_range(1, 6);
                    repeat (k)
                    begin
                        idx = 5'($urandom);
                        touched.push_back(idx);
                        send_request(shld_pkg::CMD_WRITE, idx, 8'($urandom), $urandom);
                    end
                    foreach (touched[i])
                        send_request(shld_pkg::CMD_READ, touched[i], 8'($urandom), $urandom);
                    sent += 2 * k;
                end
                5, 6:
                begin
                    amt = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 33));
                    send_request(shld_pkg::CMD_SCROLL, 5'($urandom), amt, $urandom);
                    k = $urandom_range(1, 4);
                    repeat (k)
                        send_request(shld_pkg::CMD_READ, 5'($urandom), 8'($urandom),
                                     $urandom);
                    sent += k + 1;
                end
                7:
                begin
                    send_request(shld_pkg::CMD_HEX, 5'($urandom), 8'($urandom), $urandom);
                    k = $urandom_range(1, 6);
                    repeat (k)
                        send_request(shld_pkg::CMD_READ, 5'($urandom_range(20, 31)),
                                     8'($urandom), $urandom);
                    sent += k + 1;
                end
                default:
                begin
                    send_request(shld_pkg::CMD_READ, 5'($urandom), 8'($urandom), $urandom);
                    sent++;
                end
            endcase
        end
    endtask

    // Receiver: long ready stretches, hard stalls and choppy phases
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    m_axis_tready <= 1'b1;
                    ready_hold    <= $urandom_range(20, 60);
                end
                1:
                begin
                    m_axis_tready <= 1'b0;
                    ready_hold    <= $urandom_range(1, 10);
                end
                default:
                begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                    ready_hold    <= $urandom_range(1, 4);
                end
            endcase
        end
        else
            ready_hold <= ready_hold - 1;
    end

    always @(posedge clk)
    begin : read_checker
        logic [31:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (read_expect_q.size() == 0)
            begin
                $display("%0t: read result with no request pending, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = read_expect_q.pop_front();
                reads_checked++;
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= shld_pkg::CMD_WRITE;
        for (int unsigned i = 0; i < shld_pkg::LINES; i++)
            screen_lines[i] = 32'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_write_read_extremes();
        test_scroll_cases();
        test_hex_layout();
        test_random_traffic(RANDOM_ITEMS);

        if (burst_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (read_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (read_expect_q.size() != 0)
            error_count++;

        $display("requests: %0d writes, %0d reads, %0d scrolls, %0d clears, %0d hex draws",
                 n_writes, n_reads, n_scrolls, n_clears, n_hex);
        $display("read results checked: %0d, errors: %0d", reads_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: scrolling_hex_line_display.f
+incdir+design
design/shld_pkg.sv
design/shld_front.sv
design/shld_queue.sv
design/shld_back.sv
design/scrolling_hex_line_display.sv
verif/scrolling_hex_line_display_tb.sv
